// ===== hw/rtl/fac_pkg.sv =====
package fac_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_WIDTH  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPLY,
        S_OUT
    } fac_state_t;

    typedef enum logic [1:0] {
        DIR_DOWN,
        DIR_UP
    } fac_dir_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_req;
        logic       scan_start;
        logic       scan_rd;
        logic       scan_step;
        logic       decide;
        logic       shift_rd;
        logic       shift_wr;
        logic       apply;
        logic       out_load;
    } fac_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       scan_done;
        logic       need_shift;
        logic       shift_done;
    } fac_sts_t;

endpackage

// ===== hw/rtl/fac_ctrl.sv =====
module fac_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  fac_pkg::fac_sts_t sts,
    output fac_pkg::fac_cmd_t cmd
);
    import fac_pkg::*;

    fac_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_SCAN_RD;
            S_SCAN_RD:  state_next = S_SCAN;
            S_SCAN:     if (sts.scan_done) state_next = S_DECIDE;
                        else state_next = S_SCAN_RD;
            S_DECIDE:   if (sts.need_shift) state_next = S_SHIFT_RD;
                        else state_next = S_APPLY;
            S_SHIFT_RD: if (sts.shift_done) state_next = S_APPLY;
                        else state_next = S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_APPLY:    state_next = S_OUT;
            S_OUT:      if (m_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready       = 1'b1;
                cmd.scan_start = s_tvalid;
            end
            S_SCAN_RD:  cmd.scan_rd  = 1'b1;
            S_SCAN:     cmd.scan_step = 1'b1;
            S_DECIDE:   cmd.decide   = 1'b1;
            S_SHIFT_RD: cmd.shift_rd = 1'b1;
            S_SHIFT_WR: cmd.shift_wr = 1'b1;
            S_APPLY:    cmd.apply    = 1'b1;
            S_OUT:      m_tvalid     = 1'b1;
            default: ;
        endcase
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("accept while result pending");
    a_scan_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_SCAN_RD)
        else $error("scan did not start");

endmodule

// ===== hw/rtl/fac_dpath.sv =====
module fac_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fac_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [fac_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_op,
    input  logic [15:0]                   in_size,
    input  logic [15:0]                   in_addr,
    input  fac_pkg::fac_cmd_t             cmd,
    output fac_pkg::fac_sts_t             sts,
    output logic [1:0]                    out_status,
    output logic [15:0]                   out_grant
);
    import fac_pkg::*;

    localparam logic [ADDR_WIDTH:0] MAXLEN = {1'b0, {ADDR_WIDTH{1'b1}}};

    // extent memory: {start, length}; entries beyond count are never used
    logic [2*ADDR_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [2*ADDR_WIDTH-1:0] rd_reg;

    logic                  fit_reg;
    logic [15:0]           base_reg, size_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  init_reg;   // table is just the pool extent

    logic                  op_reg;
    logic [ADDR_WIDTH-1:0] rsize_reg, raddr_reg;
    logic [CNT_W-1:0]      i_reg;      // scan index
    logic [CNT_W-1:0]      pos_reg;    // release insert point
    logic                  found_reg;
    logic [IDX_W-1:0]      pick_reg;
    logic [ADDR_WIDTH-1:0] pick_st_reg, pick_len_reg;
    logic                  pv_ok_reg;  // entry pos-1 seen
    logic [ADDR_WIDTH-1:0] pv_st_reg, pv_len_reg;
    logic                  nx_ok_reg;
    logic [ADDR_WIDTH-1:0] nx_st_reg, nx_len_reg;

    // action chosen at decide
    typedef enum logic [2:0] {
        ACT_NONE, ACT_CARVE, ACT_DEL, ACT_MERGE_P, ACT_MERGE_PN, ACT_MERGE_N, ACT_INS
    } fac_act_t;
    fac_act_t              act_reg;
    logic [1:0]            stat_reg;
    logic [CNT_W-1:0]      sh_reg;     // shift cursor
    logic [CNT_W-1:0]      sh_end_reg;
    fac_dir_t              dir_reg;

    logic [ADDR_WIDTH-1:0] e_st, e_len;
    assign e_st  = init_reg ? base_reg : rd_reg[2*ADDR_WIDTH-1:ADDR_WIDTH];
    assign e_len = init_reg ? size_reg : rd_reg[ADDR_WIDTH-1:0];

    logic [CNT_W-1:0] cnt_init;
    assign cnt_init = (size_reg != '0) ? CNT_W'(1) : '0;

    // memory read address mux
    logic [IDX_W-1:0] rd_addr;
    always_comb begin
        if (cmd.shift_rd) begin
            rd_addr = (dir_reg == DIR_DOWN) ? sh_reg[IDX_W-1:0] + IDX_W'(1)
                                            : sh_reg[IDX_W-1:0] - IDX_W'(1);
        end else begin
            rd_addr = i_reg[IDX_W-1:0];
        end
    end

    // scan-step helpers
    logic [ADDR_WIDTH:0] pv_end, rq_end;
    assign pv_end = {1'b0, pv_st_reg} + {1'b0, pv_len_reg};
    assign rq_end = {1'b0, raddr_reg} + {1'b0, rsize_reg};
    logic [ADDR_WIDTH:0] sum1, sum2;
    assign sum1 = {1'b0, pv_len_reg} + {1'b0, rsize_reg};
    assign sum2 = {1'b0, nx_len_reg} + {1'b0, rsize_reg};
    logic [ADDR_WIDTH-1:0] sat1;
    assign sat1 = (sum1 > MAXLEN) ? MAXLEN[ADDR_WIDTH-1:0] : sum1[ADDR_WIDTH-1:0];
    logic [ADDR_WIDTH:0] sum3;
    assign sum3 = {1'b0, sat1} + {1'b0, nx_len_reg};

    logic scanning_rel;
    assign scanning_rel = op_reg;
    logic last_scan;
    assign last_scan = (i_reg + CNT_W'(1) >= cnt_reg);

    always_ff @(posedge aclk) begin
        if (cmd.scan_rd || cmd.shift_rd) rd_reg <= mem[rd_addr];
        if (cmd.shift_wr) mem[sh_reg[IDX_W-1:0]] <= rd_reg;
        if (init_reg && cmd.shift_wr) mem[0] <= {base_reg, size_reg};
        if (cmd.apply && !init_reg) begin
            unique case (act_reg)
                ACT_CARVE:    mem[pick_reg] <= {pick_st_reg + rsize_reg,
                                                pick_len_reg - rsize_reg};
                ACT_MERGE_P:  mem[pos_reg[IDX_W-1:0] - IDX_W'(1)] <= {pv_st_reg, sat1};
                ACT_MERGE_PN: mem[pos_reg[IDX_W-1:0] - IDX_W'(1)] <= {pv_st_reg,
                    (sum3 > MAXLEN) ? MAXLEN[ADDR_WIDTH-1:0] : sum3[ADDR_WIDTH-1:0]};
                ACT_MERGE_N:  mem[pos_reg[IDX_W-1:0]] <= {raddr_reg,
                    (sum2 > MAXLEN) ? MAXLEN[ADDR_WIDTH-1:0] : sum2[ADDR_WIDTH-1:0]};
                ACT_INS:      mem[pos_reg[IDX_W-1:0]] <= {raddr_reg, rsize_reg};
                default: ;
            endcase
        end
        if (cmd.apply && init_reg) begin
            // table held only the pool extent in registers; materialize result
            unique case (act_reg)
                ACT_CARVE:    mem[0] <= {pick_st_reg + rsize_reg, pick_len_reg - rsize_reg};
                ACT_MERGE_P:  mem[0] <= {pv_st_reg, sat1};
                ACT_MERGE_PN: mem[0] <= {pv_st_reg,
                    (sum3 > MAXLEN) ? MAXLEN[ADDR_WIDTH-1:0] : sum3[ADDR_WIDTH-1:0]};
                ACT_MERGE_N:  mem[0] <= {raddr_reg,
                    (sum2 > MAXLEN) ? MAXLEN[ADDR_WIDTH-1:0] : sum2[ADDR_WIDTH-1:0]};
                ACT_INS: begin
                    mem[pos_reg[IDX_W-1:0]] <= {raddr_reg, rsize_reg};
                    if (pos_reg == '0) mem[1] <= {base_reg, size_reg};
                    else mem[0] <= {base_reg, size_reg};
                end
                // unchanged pool extent still has to land in memory
                default:      mem[0] <= {base_reg, size_reg};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_reg  <= 1'b0;
            base_reg <= '0;
            size_reg <= 16'hFFFF;
            cnt_reg  <= CNT_W'(1);
            init_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_FIT_MODE:  fit_reg <= cfg_data[0];
                CFG_POOL_BASE: begin
                    base_reg <= cfg_data;
                    cnt_reg  <= (size_reg != '0) ? CNT_W'(1) : '0;
                    init_reg <= 1'b1;
                end
                CFG_POOL_SIZE: begin
                    size_reg <= cfg_data;
                    cnt_reg  <= (cfg_data != '0) ? CNT_W'(1) : '0;
                    init_reg <= 1'b1;
                end
                default: ;
            endcase
        end else if (cmd.apply) begin
            init_reg <= 1'b0;
            unique case (act_reg)
                ACT_DEL, ACT_MERGE_PN: cnt_reg <= cnt_reg - CNT_W'(1);
                ACT_INS:               cnt_reg <= cnt_reg + CNT_W'(1);
                default: ;
            endcase
        end
    end

    // initial-table shortcut: count check uses cnt_init already in cnt_reg
    logic unused_ok;
    assign unused_ok = cmd.load_req & (cnt_init == cnt_reg);

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            op_reg    <= in_op;
            rsize_reg <= in_size;
            raddr_reg <= in_addr;
            i_reg     <= '0;
            pos_reg   <= '0;
            found_reg <= 1'b0;
            pv_ok_reg <= 1'b0;
            nx_ok_reg <= 1'b0;
        end
        if (cmd.scan_step && (i_reg < cnt_reg) && !unused_ok) begin
            i_reg <= i_reg + CNT_W'(1);
            if (!scanning_rel) begin
                if (e_len >= rsize_reg) begin
                    if (!found_reg ||
                        (!fit_reg && e_len < pick_len_reg) ||
                        (fit_reg && e_len > pick_len_reg)) begin
                        pick_reg     <= i_reg[IDX_W-1:0];
                        pick_st_reg  <= e_st;
                        pick_len_reg <= e_len;
                    end
                    found_reg <= 1'b1;
                end
            end else if (!nx_ok_reg) begin
                if (e_st <= raddr_reg) begin
                    pos_reg    <= i_reg + CNT_W'(1);
                    pv_ok_reg  <= 1'b1;
                    pv_st_reg  <= e_st;
                    pv_len_reg <= e_len;
                end else begin
                    nx_ok_reg  <= 1'b1;
                    nx_st_reg  <= e_st;
                    nx_len_reg <= e_len;
                end
            end
        end
        if (cmd.decide) begin
            stat_reg <= ST_DONE;
            act_reg  <= ACT_NONE;
            if (!op_reg) begin
                if (!found_reg) stat_reg <= ST_NO_FIT;
                else if (rsize_reg == '0) act_reg <= ACT_NONE;
                else if (pick_len_reg == rsize_reg) begin
                    act_reg    <= ACT_DEL;
                    dir_reg    <= DIR_DOWN;
                    sh_reg     <= CNT_W'(pick_reg);
                    sh_end_reg <= cnt_reg - CNT_W'(1);
                end else act_reg <= ACT_CARVE;
            end else if (rsize_reg != '0) begin
                if (pv_ok_reg && pv_end == {1'b0, raddr_reg}) begin
                    if (nx_ok_reg && rq_end == {1'b0, nx_st_reg}) begin
                        act_reg    <= ACT_MERGE_PN;
                        dir_reg    <= DIR_DOWN;
                        sh_reg     <= pos_reg;
                        sh_end_reg <= cnt_reg - CNT_W'(1);
                    end else act_reg <= ACT_MERGE_P;
                end else if (nx_ok_reg && rq_end == {1'b0, nx_st_reg}) begin
                    act_reg <= ACT_MERGE_N;
                end else if (cnt_reg >= CNT_W'(TABLE_DEPTH)) begin
                    stat_reg <= ST_FULL;
                end else begin
                    act_reg    <= ACT_INS;
                    dir_reg    <= DIR_UP;
                    sh_reg     <= cnt_reg;
                    sh_end_reg <= pos_reg;
                end
            end
        end
        if (cmd.shift_wr) begin
            sh_reg <= (dir_reg == DIR_DOWN) ? sh_reg + CNT_W'(1) : sh_reg - CNT_W'(1);
        end
        if (cmd.apply) begin
            out_status <= stat_reg;
            out_grant  <= (!op_reg && found_reg) ? pick_st_reg : '0;
        end
    end

    // shifting is needed only when the table lives in memory
    logic shift_act;
    assign shift_act = (act_reg == ACT_DEL) || (act_reg == ACT_MERGE_PN) ||
                       (act_reg == ACT_INS);
    assign sts.scan_done  = last_scan || (cnt_reg == '0);
    assign sts.need_shift = 1'b1;
    assign sts.shift_done = !shift_act || init_reg || (sh_reg == sh_end_reg);

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("extent count overflow");
    a_full_no_ins: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply && act_reg == ACT_INS |-> cnt_reg < CNT_W'(TABLE_DEPTH))
        else $error("insert into full table");
    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply && op_reg |=> out_grant == '0)
        else $error("release with grant");

endmodule

// ===== hw/rtl/fit_allocator_with_coalescing_unit.sv =====
// Channel | Dir | tdata (low bit up)                      | tuser
// s_      | in  | req_size[15:0], req_addr[31:16]          | op
// m_      | out | status[1:0], grant_addr[17:2], pad 0     | -
// cfg     | in  | cfg_we, cfg_index[1:0], cfg_data[15:0]    | -
//
// Each item is scanned and, when entries move, shifted before the next is
// accepted: the single-port extent memory is read once per scan step and
// once per shifted entry, and m_tready low holds the block as well.
// Reset (synchronous, aresetn low) loads the table with the single pool extent.
// A waiting result holds the block; no item is taken until it is accepted.
module fit_allocator_with_coalescing_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_size, req_addr
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status, grant_addr, zero pad
    input  logic        cfg_we,
    input  logic [fac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fac_pkg::CFG_W-1:0]     cfg_data
);
    import fac_pkg::*;

    fac_cmd_t   cmd;
    fac_sts_t   sts;
    logic [1:0]  status;
    logic [15:0] grant;

    fac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fac_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_index),
        .cfg_data   (cfg_data),
        .in_op      (s_tuser),
        .in_size    (s_tdata[15:0]),
        .in_addr    (s_tdata[31:16]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (status),
        .out_grant  (grant)
    );

    assign m_tdata = {6'b0, grant, status};

endmodule
